[sv/gbs_pkg.sv]
package gbs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field and register widths
   localparam int GRAY_W = 8;
   localparam int REG_W  = 11;
   localparam int SUM_W  = 8;

   // counters and clamped dimensions
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 2);   // flush rows h and h+1
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

   // line buffers and window hold floor(gray/9) = floor((r+g+b)/27), at most 28
   localparam int Q_W       = 5;
   localparam int RGB_SUM_W = 10;
   localparam int RECIP_W   = 10;
   localparam int RECIP27   = 607;                   // ceil(2^14 / 27)
   localparam int RECIP_SH  = 14;
   localparam int PROD_W    = RGB_SUM_W + RECIP_W;

   localparam logic [REG_W-1:0] FRAME_WIDTH_RESET  = REG_W'(640);
   localparam logic [REG_W-1:0] FRAME_HEIGHT_RESET = REG_W'(480);

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [GRAY_W-1:0] red;
      logic [GRAY_W-1:0] green;
      logic [GRAY_W-1:0] blue;
      logic              is_pixel;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] smoothed;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [WDIM_W-1:0] width;
      logic [HDIM_W-1:0] height;
      logic              restart;
   } dims_type;

   // bit 0: offset -1, bit 1: offset 0, bit 2: offset +1
   typedef struct packed {
      logic [2:0] row_ok;
      logic [2:0] col_ok;
   } nbr_mask_type;

endpackage

[sv/gbs_csr.sv]
module gbs_csr import gbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output dims_type          dims
);

   logic [REG_W-1:0] width_ff, width_in;
   logic [REG_W-1:0] height_ff, height_in;
   logic             wr;
   csr_reg_type      sel;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign sel        = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (sel)
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[REG_W-1:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[REG_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (sel)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // a zero dimension is used as 1, oversize saturates
   always_comb begin
      if (width_ff == '0)
         dims.width = WDIM_W'(1);
      else if (int'(width_ff) > MAX_WIDTH)
         dims.width = WDIM_W'(MAX_WIDTH);
      else
         dims.width = WDIM_W'(width_ff);

      if (height_ff == '0)
         dims.height = HDIM_W'(1);
      else if (int'(height_ff) > MAX_HEIGHT)
         dims.height = HDIM_W'(MAX_HEIGHT);
      else
         dims.height = HDIM_W'(height_ff);

      dims.restart = wr;
   end

endmodule

[sv/gbs_linebuf.sv]
module gbs_linebuf import gbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [Q_W-1:0]   wr_q,
   output logic [Q_W-1:0]   col_above,
   output logic [Q_W-1:0]   col_cur
);

   // Two rows back and one row back. A write moves the column's current
   // entry up and stores the new one, using the read data of that column.
   logic [Q_W-1:0] mem_above [MAX_WIDTH];
   logic [Q_W-1:0] mem_cur   [MAX_WIDTH];

   logic [Q_W-1:0] above_q_ff;
   logic [Q_W-1:0] cur_q_ff;
   logic           fwd_ff, fwd_in;
   logic [Q_W-1:0] fwd_above_ff;
   logic [Q_W-1:0] fwd_cur_ff;

   // read of the column being written in the same cycle sees the new data
   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         above_q_ff <= mem_above[rd_addr];
         cur_q_ff   <= mem_cur[rd_addr];
      end
      if (wr_en) begin
         mem_above[wr_addr] <= col_cur;
         mem_cur[wr_addr]   <= wr_q;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_in) begin
         fwd_above_ff <= col_cur;
         fwd_cur_ff   <= wr_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign col_above = fwd_ff ? fwd_above_ff : above_q_ff;
   assign col_cur   = fwd_ff ? fwd_cur_ff   : cur_q_ff;

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && rd_addr == wr_addr) |=> fwd_ff)
      else $error("same-column read did not take forwarded data");

endmodule

[sv/gbs_window.sv]
module gbs_window import gbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [Q_W-1:0]   col_above,
   input  logic [Q_W-1:0]   col_cur,
   input  logic [Q_W-1:0]   col_new,
   input  nbr_mask_type     mask,
   output logic [SUM_W-1:0] sum
);

   // index = column * 3 + row, column 0 is the oldest
   logic [Q_W-1:0]   win_ff [9];
   logic [Q_W-1:0]   win_in [9];
   logic [SUM_W-1:0] col_sum [3];

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_in[k] = win_ff[k + 3];
      end
      win_in[6] = col_above;
      win_in[7] = col_cur;
      win_in[8] = col_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (step) begin
         win_ff <= win_in;
      end
   end

   // out-of-frame neighbors add nothing
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_sum[c] = '0;
         for (int r = 0; r < 3; r++) begin
            if (mask.col_ok[c] && mask.row_ok[r]) begin
               col_sum[c] = col_sum[c] + SUM_W'(win_in[c * 3 + r]);
            end
         end
      end
      sum = col_sum[0] + col_sum[1] + col_sum[2];
   end

endmodule

[sv/gbs_out_fifo.sv]
module gbs_out_fifo import gbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_type            push_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   output logic [FIFO_CW-1:0] level
);

   rsp_type             slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]  level_ff, level_in;
   logic                pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      level_in  = level_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (level_ff < FIFO_CW'(FIFO_DEPTH)) || pop)
      else $error("output queue overflow");

endmodule

[sv/gray_box_smoothing_3x3.sv]
// 3x3 box smoothing of a gray image, streamed in raster order. Each RGB item
// becomes gray = floor((R+G+B)/3), and each output pixel is the sum of
// floor(gray/9) over its in-frame 3x3 neighbors, so edges come out darker.
// One item per clock while req_ready is high: an item is read from the line
// buffers in the cycle it is taken and written back the next, with same-column
// forwarding; its result goes to the output queue. req_ready drops only when
// the four-entry output queue is close to full. Results lag input by one row
// plus one pixel; send frame_width + 1 flush items (is_pixel = 0) after the
// last pixel to drain the frame; frame_end marks its last pixel. Flush items
// sent while pixels are still expected are dropped. A write to frame_width
// or frame_height restarts the frame; write only while the block is idle.
// Line buffer contents are never cleared: every entry that can reach an
// output was written earlier in the same frame, so no clearing pass exists.
module gray_box_smoothing_3x3 import gbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   dims_type           dims;
   logic [WDIM_W-1:0]  w_last;
   logic [HDIM_W-1:0]  h_last;

   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [IROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [OROW_W-1:0]  out_row_ff, out_row_in;

   logic               take, drop, work, emit, last;
   logic [RGB_SUM_W-1:0] rgb_sum;
   logic [PROD_W-1:0]  prod;
   logic [Q_W-1:0]     q;
   nbr_mask_type       mask;

   logic               p1_valid_ff, p1_emit_ff, p1_last_ff;
   logic [Q_W-1:0]     p1_q_ff;
   logic [COL_W-1:0]   p1_col_ff;
   nbr_mask_type       p1_mask_ff;

   logic [Q_W-1:0]     col_above, col_cur;
   logic [SUM_W-1:0]   sum;
   rsp_type            push_data;
   logic [FIFO_CW-1:0] level;

   gbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   assign w_last = dims.width  - WDIM_W'(1);
   assign h_last = dims.height - HDIM_W'(1);

   // room for the item in flight plus the one being taken
   assign req_ready = (level + FIFO_CW'(p1_emit_ff)) < FIFO_CW'(FIFO_DEPTH - 1) + FIFO_CW'(1);
   assign take      = req_valid && req_ready;
   assign drop      = (in_row_ff < IROW_W'(dims.height)) && !req_data.is_pixel;
   assign work      = take && !drop;

   assign emit = (in_row_ff >= IROW_W'(2))
              || ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0));
   assign last = (HDIM_W'(out_row_ff) == h_last) && (WDIM_W'(out_col_ff) == w_last);

   // once the frame's pixels are in, any item is a flush with gray zero
   always_comb begin
      if (in_row_ff < IROW_W'(dims.height))
         rgb_sum = RGB_SUM_W'(req_data.red) + RGB_SUM_W'(req_data.green)
                 + RGB_SUM_W'(req_data.blue);
      else
         rgb_sum = '0;
      prod = PROD_W'(rgb_sum) * PROD_W'(RECIP27);
      q    = prod[RECIP_SH +: Q_W];
   end

   always_comb begin
      mask.row_ok = {HDIM_W'(out_row_ff) != h_last, 1'b1, out_row_ff != '0};
      mask.col_ok = {WDIM_W'(out_col_ff) != w_last, 1'b1, out_col_ff != '0};
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      priority if (dims.restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (work) begin
         if (WDIM_W'(in_col_ff) == w_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit && last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (emit) begin
            if (WDIM_W'(out_col_ff) == w_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         p1_valid_ff <= 1'b0;
         p1_emit_ff  <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         p1_valid_ff <= work;
         p1_emit_ff  <= work && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         p1_last_ff <= last;
         p1_q_ff    <= q;
         p1_col_ff  <= in_col_ff;
         p1_mask_ff <= mask;
      end
   end

   gbs_linebuf u_linebuf (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (work),
      .rd_addr   (in_col_ff),
      .wr_en     (p1_valid_ff),
      .wr_addr   (p1_col_ff),
      .wr_q      (p1_q_ff),
      .col_above (col_above),
      .col_cur   (col_cur)
   );

   gbs_window u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (p1_valid_ff),
      .col_above (col_above),
      .col_cur   (col_cur),
      .col_new   (p1_q_ff),
      .mask      (p1_mask_ff),
      .sum       (sum)
   );

   assign push_data.smoothed  = sum;
   assign push_data.frame_end = p1_last_ff;

   gbs_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (p1_emit_ff),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (level)
   );

   a_emit_needs_item: assert property (@(posedge clock) disable iff (reset)
      p1_emit_ff |-> p1_valid_ff)
      else $error("result without a pipelined item");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (p1_emit_ff && p1_last_ff) |-> (out_row_ff == '0) && (out_col_ff == '0))
      else $error("output position not cleared after frame end");

   a_out_in_frame: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (WDIM_W'(out_col_ff) <= w_last) && (HDIM_W'(out_row_ff) <= h_last))
      else $error("output position outside the frame");

endmodule
